// ===== rtl/core/buzzer_tone_sequencer_defines.svh =====
// Assertion macros for the buzzer tone sequencer checker.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef BUZZER_TONE_SEQUENCER_DEFINES_SVH
`define BUZZER_TONE_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("buzzer tone sequencer check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("buzzer tone sequencer check failed");

`endif

// ===== rtl/core/bts_pkg.sv =====
// Shared types and codes for the buzzer tone sequencer.
// No dependencies; imported by bts_cmd_store, bts_phase_seq and the top level.
`default_nettype none

package bts_pkg;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_TONE = 2'd1;
	localparam logic [1:0] REQ_STOP = 2'd2;

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_ON1  = 4'b0010,
		PH_ON2  = 4'b0100,
		PH_HOLD = 4'b1000
	} phase_t;

	// Decoded request of the item leaving the input register
	typedef struct packed {
		logic advance;
		logic tick;
		logic tone;
		logic stop;
	} bts_step_t;

endpackage

`default_nettype wire

// ===== rtl/core/bts_req_if.sv =====
// Request channel of the buzzer tone sequencer: valid/ready plus item fields.
// No dependencies.
`default_nettype none

interface bts_req_if #(
	parameter int TIME_WIDTH   = 16,
	parameter int REPEAT_WIDTH = 8,
	parameter int FREQ_WIDTH   = 16
);
	logic                    valid;
	logic                    ready;
	logic [1:0]              req_type;
	logic [TIME_WIDTH-1:0]   on_time;
	logic [TIME_WIDTH-1:0]   off_time;
	logic [REPEAT_WIDTH-1:0] repeat_count;
	logic [FREQ_WIDTH-1:0]   freq_one;
	logic [FREQ_WIDTH-1:0]   freq_two;

	modport source (
		output valid, req_type, on_time, off_time, repeat_count, freq_one, freq_two,
		input  ready
	);
	modport sink (
		input  valid, req_type, on_time, off_time, repeat_count, freq_one, freq_two,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/bts_res_if.sv =====
// Result channel of the buzzer tone sequencer: valid/ready plus result fields.
// No dependencies.
`default_nettype none

interface bts_res_if #(
	parameter int FREQ_WIDTH = 16
);
	logic                  valid;
	logic                  ready;
	logic                  tone_write;
	logic [FREQ_WIDTH-1:0] tone_value;
	logic                  accepted;
	logic                  busy_res;

	modport source (
		output valid, tone_write, tone_value, accepted, busy_res,
		input  ready
	);
	modport sink (
		input  valid, tone_write, tone_value, accepted, busy_res,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/core/bts_cmd_store.sv =====
// Command store: acceptance check and the held pattern (times, tones, repeat).
// Depends on bts_pkg.
`default_nettype none

module bts_cmd_store import bts_pkg::*; #(
	parameter int TIME_WIDTH   = 16,
	parameter int REPEAT_WIDTH = 8,
	parameter int FREQ_WIDTH   = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire bts_step_t               step,
	input  wire logic                    phase_idle,
	input  wire logic [TIME_WIDTH-1:0]   on_time,
	input  wire logic [TIME_WIDTH-1:0]   off_time,
	input  wire logic [REPEAT_WIDTH-1:0] repeat_count,
	input  wire logic [FREQ_WIDTH-1:0]   freq_one,
	input  wire logic [FREQ_WIDTH-1:0]   freq_two,
	output logic                         take,
	output logic [TIME_WIDTH-1:0]        high_time_q,
	output logic [TIME_WIDTH-1:0]        low_time_q,
	output logic [FREQ_WIDTH-1:0]        freq_one_q,
	output logic [FREQ_WIDTH-1:0]        freq_two_q,
	output logic [REPEAT_WIDTH-1:0]      repeat_q
);

	localparam logic [TIME_WIDTH-1:0] TimeMax = {TIME_WIDTH{1'b1}};

	logic [TIME_WIDTH-1:0] on_eff, off_eff, high_d, low_d;

	assign take = step.advance && (step.tone || step.stop) &&
		(repeat_q == '0 || phase_idle);

	// A stop behaves like a tone command with every field zero
	assign on_eff  = step.stop ? '0 : on_time;
	assign off_eff = step.stop ? '0 : off_time;

	always_comb begin
		if (on_eff == TimeMax) begin
			high_d = TimeMax;
		end else if (on_eff != '0) begin
			high_d = (on_eff >> 1) + TIME_WIDTH'(1);
		end else begin
			high_d = '0;
		end
		if (off_eff == '0 || off_eff == TimeMax) begin
			low_d = off_eff;
		end else begin
			low_d = off_eff + TIME_WIDTH'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_time_q <= '0;
			low_time_q  <= '0;
			freq_one_q  <= '0;
			freq_two_q  <= '0;
			repeat_q    <= '0;
		end else if (take) begin
			high_time_q <= high_d;
			low_time_q  <= low_d;
			freq_one_q  <= step.stop ? '0 : freq_one;
			freq_two_q  <= step.stop ? '0 : freq_two;
			repeat_q    <= step.stop ? '0 : repeat_count;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/bts_phase_seq.sv =====
// Phase sequencer: tick-driven phase, timer and repeat counting, tone writes.
// Depends on bts_pkg and the held pattern from bts_cmd_store.
`default_nettype none

module bts_phase_seq import bts_pkg::*; #(
	parameter int TIME_WIDTH   = 16,
	parameter int REPEAT_WIDTH = 8,
	parameter int FREQ_WIDTH   = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire bts_step_t               step,
	input  wire logic                    take,
	input  wire logic [TIME_WIDTH-1:0]   high_time,
	input  wire logic [TIME_WIDTH-1:0]   low_time,
	input  wire logic [FREQ_WIDTH-1:0]   freq_one,
	input  wire logic [FREQ_WIDTH-1:0]   freq_two,
	input  wire logic [REPEAT_WIDTH-1:0] repeat_cfg,
	output logic                         phase_idle,
	output logic                         tone_write,
	output logic [FREQ_WIDTH-1:0]        tone_value,
	output logic                         busy
);

	localparam logic [TIME_WIDTH-1:0] TimeMax = {TIME_WIDTH{1'b1}};

	phase_t                  phase_q, phase_d;
	logic [TIME_WIDTH-1:0]   timer_q, timer_d;
	logic [REPEAT_WIDTH-1:0] repeats_q, repeats_d;
	logic                    fresh_q, fresh_d;
	logic                    armed_q, armed_d;

	assign phase_idle = (phase_q == PH_IDLE);

	always_comb begin
		phase_d    = phase_q;
		timer_d    = timer_q;
		repeats_d  = repeats_q;
		fresh_d    = fresh_q;
		armed_d    = armed_q;
		tone_write = 1'b0;
		tone_value = '0;
		if (step.tick) begin
			unique case (phase_q)
				PH_IDLE: begin
					if (armed_q) begin
						repeats_d = repeat_cfg;
						fresh_d   = 1'b0;
						phase_d   = PH_HOLD;
					end
				end
				PH_ON1: begin
					// all-ones timer: continuous tone, stay here
					if (timer_q == TimeMax) begin
						phase_d = PH_ON1;
					end else if (timer_q != '0) begin
						timer_d = timer_q - TIME_WIDTH'(1);
					end else begin
						if (freq_two != '0) begin
							tone_write = 1'b1;
							tone_value = freq_two;
						end
						timer_d = high_time;
						phase_d = PH_ON2;
					end
				end
				PH_ON2: begin
					if (timer_q != '0) begin
						timer_d = timer_q - TIME_WIDTH'(1);
					end else begin
						phase_d = PH_HOLD;
						if (low_time != '0) begin
							timer_d    = low_time;
							tone_write = 1'b1;
						end
					end
				end
				PH_HOLD: begin
					if (timer_q != '0) begin
						timer_d = timer_q - TIME_WIDTH'(1);
					end else if (fresh_q) begin
						tone_write = 1'b1;
						phase_d    = PH_IDLE;
					end else if (high_time == '0) begin
						armed_d    = 1'b0;
						tone_write = 1'b1;
						phase_d    = PH_IDLE;
					end else if (repeats_q != '0 || repeat_cfg == '0) begin
						// a zero repeat setting loops forever
						if (repeats_q != '0) begin
							repeats_d = repeats_q - REPEAT_WIDTH'(1);
						end
						timer_d    = high_time;
						tone_write = 1'b1;
						tone_value = freq_one;
						phase_d    = PH_ON1;
					end else begin
						armed_d    = 1'b0;
						tone_write = 1'b1;
						phase_d    = PH_IDLE;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		if (take) begin
			armed_d = 1'b1;
			fresh_d = 1'b1;
		end
		if (step.stop) begin
			timer_d = '0;
		end
		busy = (phase_d != PH_IDLE) || fresh_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			timer_q   <= '0;
			repeats_q <= '0;
			fresh_q   <= 1'b0;
			armed_q   <= 1'b0;
		end else if (step.advance) begin
			phase_q   <= phase_d;
			timer_q   <= timer_d;
			repeats_q <= repeats_d;
			fresh_q   <= fresh_d;
			armed_q   <= armed_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/buzzer_tone_sequencer.sv =====
// Top level of the buzzer tone sequencer: input register, store, sequencer,
// result register. Depends on bts_pkg, bts_req_if, bts_res_if,
// bts_cmd_store and bts_phase_seq.
//
//   port     dir  handshake     carries
//   in_req   in   valid/ready   req_type, on_time, off_time, repeat_count, freq_one, freq_two
//   out_res  out  valid/ready   tone_write, tone_value, accepted, busy_res
//
// One item per clock sustained while out_res.ready stays high; every item gives one result
// after acceptance, through the input register and then the result register.
// The single state update between the two registers sets the one-cycle rate.
// Reset (arst_n low) empties both registers and returns to idle, no pattern.
// While a result waits on out_res.ready the input register holds; in_req.ready
// drops only once both registers are full.
`default_nettype none

module buzzer_tone_sequencer import bts_pkg::*; #(
	parameter int TIME_WIDTH   = 16,
	parameter int REPEAT_WIDTH = 8,
	parameter int FREQ_WIDTH   = 16
) (
	input wire logic  clk,
	input wire logic  arst_n,
	bts_req_if.sink   in_req,
	bts_res_if.source out_res
);

	logic                    valid_s1;
	logic [1:0]              req_s1;
	logic [TIME_WIDTH-1:0]   on_s1, off_s1;
	logic [REPEAT_WIDTH-1:0] rep_s1;
	logic [FREQ_WIDTH-1:0]   f1_s1, f2_s1;

	logic                    out_valid_q;
	logic                    tone_write_q;
	logic [FREQ_WIDTH-1:0]   tone_value_q;
	logic                    accepted_q;
	logic                    busy_q;

	logic                    out_free, in_acc;
	bts_step_t               step;
	logic                    take, phase_idle;
	logic                    tone_write, busy;
	logic [FREQ_WIDTH-1:0]   tone_value;
	logic [TIME_WIDTH-1:0]   high_time, low_time;
	logic [FREQ_WIDTH-1:0]   freq_one, freq_two;
	logic [REPEAT_WIDTH-1:0] repeat_cfg;

	assign out_free     = !out_valid_q || out_res.ready;
	assign in_req.ready = !valid_s1 || out_free;
	assign in_acc       = in_req.valid && in_req.ready;

	always_comb begin
		step         = '0;
		step.advance = valid_s1 && out_free;
		unique case (req_s1)
			REQ_TICK: step.tick = step.advance;
			REQ_TONE: step.tone = step.advance;
			REQ_STOP: step.stop = step.advance;
			default:  step.tick = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (step.advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1 <= in_req.req_type;
			on_s1  <= in_req.on_time;
			off_s1 <= in_req.off_time;
			rep_s1 <= in_req.repeat_count;
			f1_s1  <= in_req.freq_one;
			f2_s1  <= in_req.freq_two;
		end
	end

	bts_cmd_store #(
		.TIME_WIDTH   (TIME_WIDTH),
		.REPEAT_WIDTH (REPEAT_WIDTH),
		.FREQ_WIDTH   (FREQ_WIDTH)
	) u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.phase_idle   (phase_idle),
		.on_time      (on_s1),
		.off_time     (off_s1),
		.repeat_count (rep_s1),
		.freq_one     (f1_s1),
		.freq_two     (f2_s1),
		.take         (take),
		.high_time_q  (high_time),
		.low_time_q   (low_time),
		.freq_one_q   (freq_one),
		.freq_two_q   (freq_two),
		.repeat_q     (repeat_cfg)
	);

	bts_phase_seq #(
		.TIME_WIDTH   (TIME_WIDTH),
		.REPEAT_WIDTH (REPEAT_WIDTH),
		.FREQ_WIDTH   (FREQ_WIDTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.take       (take),
		.high_time  (high_time),
		.low_time   (low_time),
		.freq_one   (freq_one),
		.freq_two   (freq_two),
		.repeat_cfg (repeat_cfg),
		.phase_idle (phase_idle),
		.tone_write (tone_write),
		.tone_value (tone_value),
		.busy       (busy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.advance) begin
			out_valid_q <= 1'b1;
		end else if (out_res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.advance) begin
			tone_write_q <= tone_write;
			tone_value_q <= tone_value;
			accepted_q   <= take;
			busy_q       <= busy;
		end
	end

	assign out_res.valid      = out_valid_q;
	assign out_res.tone_write = tone_write_q;
	assign out_res.tone_value = tone_value_q;
	assign out_res.accepted   = accepted_q;
	assign out_res.busy_res   = busy_q;

endmodule

`default_nettype wire

// ===== rtl/core/bts_checker.sv =====
// Port-level checks for the buzzer tone sequencer, bound to the top level.
// Depends on buzzer_tone_sequencer_defines.svh and buzzer_tone_sequencer.
`default_nettype none
`include "buzzer_tone_sequencer_defines.svh"

module bts_checker #(
	parameter int FREQ_WIDTH = 16
) (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire logic                  tone_write,
	input wire logic [FREQ_WIDTH-1:0] tone_value,
	input wire logic                  accepted,
	input wire logic                  busy_res
);

	// a stalled result holds its valid, tone write and tone value
	`BTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tone_value) && $stable(tone_write))
	// no tone write means a zero tone value
	`BTS_ASSERT_NOW(a_quiet_zero, out_valid && !tone_write, tone_value == '0)
	// a taken command leaves a pending pattern
	`BTS_ASSERT_NOW(a_acc_busy, out_valid && accepted, busy_res)
	// a sounding tone is only written while a pattern plays
	`BTS_ASSERT_NOW(a_tone_busy, out_valid && tone_write && tone_value != '0, busy_res)

endmodule

bind buzzer_tone_sequencer bts_checker #(
	.FREQ_WIDTH (FREQ_WIDTH)
) u_bts_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_res.valid),
	.out_ready  (out_res.ready),
	.tone_write (out_res.tone_write),
	.tone_value (out_res.tone_value),
	.accepted   (out_res.accepted),
	.busy_res   (out_res.busy_res)
);

`default_nettype wire

// ===== tb/tb_buzzer_tone_sequencer.sv =====
`timescale 1ns / 1ps
// Testbench for buzzer_tone_sequencer: a directed table, then random tone, stop and unused
// items with tick bursts; typed rows check their own result, the rest a behavioral model.
// Depends on bts_pkg, bts_req_if, bts_res_if and the block's RTL.

module tb_buzzer_tone_sequencer;
	import bts_pkg::*;

	localparam int TIME_W = 16;
	localparam int REP_W = 8;
	localparam int FREQ_W = 16;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 1825;
	localparam int HOLD_OFF_CYCLES = 150;
	localparam int DRAIN_CYCLES = 8;
	localparam int REPORT_LIMIT = 40;

	typedef struct packed {
		logic [1:0]        kind;
		logic [TIME_W-1:0] on_t;
		logic [TIME_W-1:0] off_t;
		logic [REP_W-1:0]  rep;
		logic [FREQ_W-1:0] f1;
		logic [FREQ_W-1:0] f2;
	} req_item_t;

	typedef struct packed {
		logic              wr;
		logic [FREQ_W-1:0] tone;
		logic              acc;
		logic              busy;
	} tone_result_t;

	// typed set: the row carries its own expected result
	typedef struct packed {
		req_item_t    item;
		logic         typed;
		tone_result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	bts_req_if #(.TIME_WIDTH(TIME_W), .REPEAT_WIDTH(REP_W), .FREQ_WIDTH(FREQ_W)) req_ch ();
	bts_res_if #(.FREQ_WIDTH(FREQ_W)) res_ch ();

	buzzer_tone_sequencer #(
		.TIME_WIDTH(TIME_W),
		.REPEAT_WIDTH(REP_W),
		.FREQ_WIDTH(FREQ_W)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_req(req_ch),
		.out_res(res_ch)
	);

	// Model state of the sequencer
	phase_t            seq_phase = PH_IDLE;
	logic [TIME_W-1:0] seq_timer = '0;
	logic [REP_W-1:0]  seq_repeats_left = '0;
	logic              seq_fresh = 1'b0;
	logic              seq_armed = 1'b0;
	logic [TIME_W-1:0] held_high_time = '0;
	logic [TIME_W-1:0] held_low_time = '0;
	logic [FREQ_W-1:0] held_freq_one = '0;
	logic [FREQ_W-1:0] held_freq_two = '0;
	logic [REP_W-1:0]  held_repeat = '0;

	stim_row_t    stim_q[$];
	tone_result_t tone_expect_q[$];
	int           total_items = 0;
	int           sent_count = 0;
	int           mismatch_count = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic store_tone_command(input req_item_t it);
		if (!(held_repeat == 0 || seq_phase == PH_IDLE))
			return 1'b0;
		if (it.on_t == '1)
			held_high_time = '1;
		else if (it.on_t != 0)
			held_high_time = (it.on_t >> 1) + TIME_W'(1);
		else
			held_high_time = '0;
		// off time saturates at all ones
		if (it.off_t == 0)
			held_low_time = '0;
		else if (it.off_t == '1)
			held_low_time = '1;
		else
			held_low_time = it.off_t + TIME_W'(1);
		held_freq_one = it.f1;
		held_freq_two = it.f2;
		held_repeat = it.rep;
		seq_armed = 1'b1;
		seq_fresh = 1'b1;
		return 1'b1;
	endfunction

	function automatic tone_result_t sequencer_step(input req_item_t it);
		tone_result_t r;
		req_item_t    blank;
		r = '0;
		blank = '0;
		case (it.kind)
			REQ_TICK: begin
				case (seq_phase)
					PH_IDLE: begin
						if (seq_armed) begin
							seq_repeats_left = held_repeat;
							seq_fresh = 1'b0;
							seq_phase = PH_HOLD;
						end
					end
					PH_ON1: begin
						// all-ones timer holds the first tone until a stop
						if (seq_timer != '1) begin
							if (seq_timer != 0) begin
								seq_timer = seq_timer - TIME_W'(1);
							end else begin
								if (held_freq_two != 0) begin
									r.wr = 1'b1;
									r.tone = held_freq_two;
								end
								seq_timer = held_high_time;
								seq_phase = PH_ON2;
							end
						end
					end
					PH_ON2: begin
						if (seq_timer != 0) begin
							seq_timer = seq_timer - TIME_W'(1);
						end else begin
							seq_phase = PH_HOLD;
							if (held_low_time != 0) begin
								seq_timer = held_low_time;
								r.wr = 1'b1;
							end
						end
					end
					default: begin
						if (seq_timer != 0) begin
							seq_timer = seq_timer - TIME_W'(1);
						end else if (seq_fresh) begin
							r.wr = 1'b1;
							seq_phase = PH_IDLE;
						end else if (held_high_time == 0 ||
								(seq_repeats_left == 0 && held_repeat != 0)) begin
							seq_armed = 1'b0;
							r.wr = 1'b1;
							seq_phase = PH_IDLE;
						end else begin
							// zero repeat count loops forever
							if (seq_repeats_left != 0)
								seq_repeats_left = seq_repeats_left - REP_W'(1);
							seq_timer = held_high_time;
							r.wr = 1'b1;
							r.tone = held_freq_one;
							seq_phase = PH_ON1;
						end
					end
				endcase
			end
			REQ_TONE: r.acc = store_tone_command(it);
			REQ_STOP: begin
				r.acc = store_tone_command(blank);
				seq_timer = '0;
			end
			default: ;
		endcase
		r.busy = (seq_phase != PH_IDLE) || seq_fresh;
		return r;
	endfunction

	function automatic req_item_t random_fields(input logic [1:0] kind);
		req_item_t it;
		it.kind = kind;
		it.on_t = TIME_W'($urandom_range(0, 65535));
		it.off_t = TIME_W'($urandom_range(0, 65535));
		it.rep = REP_W'($urandom_range(0, 255));
		it.f1 = FREQ_W'($urandom_range(0, 65535));
		it.f2 = FREQ_W'($urandom_range(0, 65535));
		return it;
	endfunction

	task automatic report_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		mismatch_count++;
		if (mismatch_count <= REPORT_LIMIT)
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
	endtask

	task automatic check_tone_result(input tone_result_t got);
		tone_result_t want;
		if (tone_expect_q.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_LIMIT)
				$display("%0t: result with nothing expected, expected none actual %h",
					$time, got);
			return;
		end
		want = tone_expect_q.pop_front();
		if (got.wr !== want.wr)
			report_field("tone_write", 32'(want.wr), 32'(got.wr));
		if (got.tone !== want.tone)
			report_field("tone_value", 32'(want.tone), 32'(got.tone));
		if (got.acc !== want.acc)
			report_field("accepted", 32'(want.acc), 32'(got.acc));
		if (got.busy !== want.busy)
			report_field("busy_res", 32'(want.busy), 32'(got.busy));
	endtask

	initial begin : sender
		stim_row_t    directed_rows [25];
		stim_row_t    row;
		tone_result_t predicted;
		int           counted;
		int           pick;
		int           burst;
		int           pct;
		bit           offering;

		req_ch.valid <= 1'b0;
		req_ch.req_type <= REQ_TICK;
		req_ch.on_time <= '0;
		req_ch.off_time <= '0;
		req_ch.repeat_count <= '0;
		req_ch.freq_one <= '0;
		req_ch.freq_two <= '0;

		// kind, on, off, repeat, freq one, freq two | typed, write, tone, accepted, busy
		directed_rows = '{
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TONE,   16'hFFFF, 16'h0000, 8'h00, 16'hFFFF, 16'h0000, 1'b1, 1'b0, 16'h0000, 1'b1, 1'b1},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b1},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b1},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TONE,   16'h0001, 16'hFFFF, 8'h01, 16'h1234, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TICK,   16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TONE,   16'h8000, 16'h0001, 8'hFF, 16'h0000, 16'h0001, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b1},
			{REQ_STOP,   16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_STOP,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_STOP,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_STOP,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0},
			{REQ_TICK,   16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0}
		};
		foreach (directed_rows[i])
			stim_q.push_back(directed_rows[i]);

		// Random part: a command, then a burst of ticks that lets the pattern play out
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			row = '0;
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				row.item = random_fields(REQ_TONE);
				case ($urandom_range(0, 15))
					0: row.item.on_t = '0;
					1: row.item.on_t = '1;
					2: ;
					3: row.item.on_t = {{(TIME_W-1){1'b1}}, 1'b0};
					default: row.item.on_t = TIME_W'($urandom_range(1, 24));
				endcase
				case ($urandom_range(0, 15))
					0, 1, 2, 3: row.item.off_t = '0;
					4: row.item.off_t = '1;
					5: row.item.off_t = {{(TIME_W-1){1'b1}}, 1'b0};
					6: ;
					default: row.item.off_t = TIME_W'($urandom_range(1, 12));
				endcase
				case ($urandom_range(0, 7))
					0, 1: row.item.rep = '0;
					2: ;
					default: row.item.rep = REP_W'($urandom_range(1, 3));
				endcase
				if ($urandom_range(0, 3) == 0)
					row.item.f2 = '0;
				counted++;
			end else if (pick < 93) begin
				row.item = random_fields(REQ_STOP);
				counted++;
			end else begin
				row.item = random_fields(REQ_UNUSED);
			end
			stim_q.push_back(row);
			burst = $urandom_range(0, 40);
			repeat (burst) begin
				row = '0;
				row.item = random_fields(REQ_TICK);
				stim_q.push_back(row);
				counted++;
			end
		end
		total_items = stim_q.size();
		offering = 1'b0;

		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (req_ch.valid && req_ch.ready) begin
				row = stim_q.pop_front();
				predicted = sequencer_step(row.item);
				tone_expect_q.push_back(row.typed ? row.want : predicted);
				sent_count++;
				offering = 1'b0;
			end
			// hold the offered item until it is taken
			if (!offering) begin
				pct = (sent_count < total_items / 3) ? 14 :
					(sent_count < 2 * total_items / 3) ? 61 : 0;
				if (stim_q.size() != 0 && $urandom_range(0, 99) >= pct) begin
					req_ch.req_type <= stim_q[0].item.kind;
					req_ch.on_time <= stim_q[0].item.on_t;
					req_ch.off_time <= stim_q[0].item.off_t;
					req_ch.repeat_count <= stim_q[0].item.rep;
					req_ch.freq_one <= stim_q[0].item.f1;
					req_ch.freq_two <= stim_q[0].item.f2;
					req_ch.valid <= 1'b1;
					offering = 1'b1;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	initial begin : receiver
		tone_result_t got;
		int           recv_count;
		int           hold_left;
		int           pct;
		bit           held_off;

		res_ch.ready <= 1'b0;
		recv_count = 0;
		hold_left = 0;
		held_off = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				got = {res_ch.tone_write, res_ch.tone_value, res_ch.accepted, res_ch.busy_res};
				check_tone_result(got);
				recv_count++;
			end
			// hold off once for a long stretch so the block fills and stalls its input
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else if (!held_off && recv_count >= total_items * 5 / 6) begin
				held_off = 1'b1;
				hold_left = HOLD_OFF_CYCLES;
				res_ch.ready <= 1'b0;
			end else begin
				pct = (recv_count < total_items / 3) ? 61 :
					(recv_count < 2 * total_items / 3) ? 14 : 0;
				res_ch.ready <= ($urandom_range(0, 99) >= pct);
			end
		end
	end

	initial begin : finisher
		wait (arst_n === 1'b1);
		do
			@(negedge clk);
		while (sent_count < total_items || tone_expect_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#1_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
